>>> sv/sac_pkg.sv
// shared types and constants for the segment access check
`timescale 1ns / 1ps

package sac_pkg;

  // descriptor kind bits
  localparam int unsigned KIND_SEG_BIT  = 4;
  localparam int unsigned KIND_CODE_BIT = 3;
  localparam int unsigned KIND_CE_BIT   = 2;
  localparam int unsigned KIND_RW_BIT   = 1;

  localparam logic [31:0] FLAT_LIMIT  = 32'hffff_ffff;
  localparam logic [31:0] SMALL_UPPER = 32'h0000_ffff;

  localparam logic [7:0] VEC_DEFAULT = 8'd255;
  localparam logic [7:0] VEC_SS      = 8'd12;
  localparam logic [7:0] VEC_GP      = 8'd13;

  typedef enum logic [2:0] {
    SAC_REASON_NONE    = 3'd0,
    SAC_REASON_INVALID = 3'd1,
    SAC_REASON_ABSENT  = 3'd2,
    SAC_REASON_RIGHTS  = 3'd3,
    SAC_REASON_LIMIT   = 3'd4
  } sac_reason_t;

  typedef struct packed {
    logic        desc_valid;
    logic        desc_present;
    logic [4:0]  desc_kind;
    logic        desc_big;
    logic [31:0] seg_limit;
    logic [31:0] seg_base;
    logic [31:0] access_offset;
    logic [4:0]  access_len;
    logic        is_write;
    logic [7:0]  vector_in;
    logic [15:0] error_code_in;
    logic        is_stack_segment;
  } sac_req_t;

  typedef struct packed {
    logic        fault;
    logic [7:0]  fault_vector;
    logic [15:0] fault_error_code;
    sac_reason_t fault_reason;
  } sac_rsp_t;

endpackage

>>> sv/sac_if.sv
// request and response channel interfaces for the segment access check
`timescale 1ns / 1ps

interface sac_req_if;
  logic              valid;
  logic              ready;
  sac_pkg::sac_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sac_rsp_if;
  logic              valid;
  logic              ready;
  sac_pkg::sac_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/sac_check.sv
// combinational fault evaluation for one segment access
`timescale 1ns / 1ps

module sac_check (
  input  sac_pkg::sac_req_t req,
  output sac_pkg::sac_rsp_t rsp
);

  logic [4:0]  last;
  logic [32:0] end_sum;
  logic [31:0] upper;
  logic        is_code;
  logic        is_ce;
  logic        is_rw;
  logic        allowed;
  logic        flat;
  logic        normal_ok;
  logic        expdown_ok;
  logic [7:0]  vec;
  sac_pkg::sac_reason_t reason;

  always_comb begin
    last    = (req.access_len == 5'd0) ? 5'd0 : req.access_len - 5'd1;
    end_sum = {1'b0, req.access_offset} + {28'd0, last};
    upper   = req.desc_big ? sac_pkg::FLAT_LIMIT : sac_pkg::SMALL_UPPER;

    is_code = req.desc_kind[sac_pkg::KIND_CODE_BIT];
    is_ce   = req.desc_kind[sac_pkg::KIND_CE_BIT];
    is_rw   = req.desc_kind[sac_pkg::KIND_RW_BIT];
    allowed = req.is_write ? (!is_code && is_rw) : (!is_code || is_rw);

    flat       = (req.seg_limit == sac_pkg::FLAT_LIMIT) && (req.seg_base == 32'd0);
    normal_ok  = flat || (end_sum <= {1'b0, req.seg_limit});
    expdown_ok = (req.access_offset > req.seg_limit) && (end_sum <= {1'b0, upper});

    if (req.vector_in == sac_pkg::VEC_DEFAULT) begin
      vec = req.is_stack_segment ? sac_pkg::VEC_SS : sac_pkg::VEC_GP;
    end else begin
      vec = req.vector_in;
    end

    if (!req.desc_valid) begin
      reason = sac_pkg::SAC_REASON_INVALID;
    end else if (!req.desc_present) begin
      reason = sac_pkg::SAC_REASON_ABSENT;
    end else if (!req.desc_kind[sac_pkg::KIND_SEG_BIT] || !allowed) begin
      reason = sac_pkg::SAC_REASON_RIGHTS;
    end else if (!is_code && is_ce) begin
      reason = expdown_ok ? sac_pkg::SAC_REASON_NONE : sac_pkg::SAC_REASON_LIMIT;
    end else begin
      reason = normal_ok ? sac_pkg::SAC_REASON_NONE : sac_pkg::SAC_REASON_LIMIT;
    end

    if (reason == sac_pkg::SAC_REASON_NONE) begin
      rsp.fault            = 1'b0;
      rsp.fault_vector     = 8'd0;
      rsp.fault_error_code = 16'd0;
      rsp.fault_reason     = sac_pkg::SAC_REASON_NONE;
    end else begin
      rsp.fault            = 1'b1;
      rsp.fault_vector     = vec;
      rsp.fault_error_code = req.error_code_in;
      rsp.fault_reason     = reason;
    end
  end

endmodule

>>> sv/segment_access_check.sv
// top level of the segment access check
//
//   channel  dir  content
//   in_ch    in   descriptor fields, offset, length, direction, vector, error code
//   out_ch   out  fault flag, vector, error code, reason
//
// one transfer per cycle sustained on both channels while out_ch.ready stays high
// a request passes through the input register, then the result register
// check logic sits between the two registers; in_ch.ready follows out_ch.ready combinationally
// reset clears both valid flags; payload registers are not reset
// a stalled result holds its register while the input register still takes one more item
`timescale 1ns / 1ps

module segment_access_check (
  input logic         clk,
  input logic         rst_n,
  sac_req_if.sink     in_ch,
  sac_rsp_if.source   out_ch
);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  sac_pkg::sac_req_t s1_req_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  sac_pkg::sac_rsp_t out_rsp_r;
  sac_pkg::sac_rsp_t chk_rsp;
  logic              s1_adv;
  logic              in_xfer;

  sac_check u_check (
    .req (s1_req_r),
    .rsp (chk_rsp)
  );

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_rsp_r;

  always_comb begin
    s1_valid_nxt  = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : ((out_valid_r && out_ch.ready) ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req_r <= in_ch.data;
    end
    if (s1_adv) begin
      out_rsp_r <= chk_rsp;
    end
  end

`ifndef SYNTHESIS
  a_in_xfer_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted request not held in input register");

  a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("checked request did not reach result register");

  a_fault_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rsp_r.fault == (out_rsp_r.fault_reason != sac_pkg::SAC_REASON_NONE)))
    else $error("fault flag disagrees with reason");

  a_clean_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp_r.fault) |->
      (out_rsp_r.fault_vector == 8'd0 && out_rsp_r.fault_error_code == 16'd0))
    else $error("non-faulting result carries vector or error code");
`endif

endmodule
